### rtl/rtpdfr_pkg.sv
// ----------------------------------------------------------------------------
// rtpdfr_pkg
// Shared types and constants of the RTP fixed-header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpdfr_pkg;

	localparam int unsigned MAX_DATAGRAM = 65536;
	localparam int unsigned FIXED_LEN    = 12;

	// byte position saturates at MAX_DATAGRAM, so it has to hold that value
	localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);
	// header length is at most 12 + 4 * 15
	localparam int unsigned HDR_W = 7;
	localparam int unsigned CMP_W = (POS_W > HDR_W) ? POS_W : HDR_W;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_CSRC    = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_DROP    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  version;
		logic        extension_flag;
		logic [3:0]  source_count;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] sequence_res;
		logic [31:0] stamp;
		logic [31:0] sync_source;
		logic [31:0] data_word;
		logic        packet_end;
	} result_t;

endpackage

`default_nettype wire

### rtl/rtpdfr_in_if.sv
// ----------------------------------------------------------------------------
// rtpdfr_in_if
// Byte channel into the deframer: one datagram byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpdfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### rtl/rtpdfr_out_if.sv
// ----------------------------------------------------------------------------
// rtpdfr_out_if
// Result channel of the deframer: header, csrc word, payload byte or drop.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtpdfr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  version;
	logic        extension_flag;
	logic [3:0]  source_count;
	logic        marker;
	logic [6:0]  payload_type;
	logic [15:0] sequence_res;
	logic [31:0] stamp;
	logic [31:0] sync_source;
	logic [31:0] data_word;
	logic        packet_end;

	modport source (
		output valid, output kind, output version, output extension_flag,
		output source_count, output marker, output payload_type,
		output sequence_res, output stamp, output sync_source,
		output data_word, output packet_end, input ready
	);
	modport sink (
		input valid, input kind, input version, input extension_flag,
		input source_count, input marker, input payload_type,
		input sequence_res, input stamp, input sync_source,
		input data_word, input packet_end, output ready
	);
endinterface

`default_nettype wire

### rtl/rtp_header_deframer_top.sv
// path: input register, then result register; not every byte gives a result
// throughput: one byte per cycle unless stalled; single header/state update stage
// an output register holds a stalled result while the next byte waits in the
// input register, so the byte channel keeps moving until both are full
// reset: asynchronous, clears the byte position, header registers and valids
// ----------------------------------------------------------------------------
// rtp_header_deframer_top
// Parses the 12-byte RTP fixed header and csrc list, passes payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_header_deframer_top (
	input  wire             clk,
	input  wire             arst_n,
	rtpdfr_in_if.sink       rx,
	rtpdfr_out_if.source    tx
);

	localparam int unsigned POS_W = rtpdfr_pkg::POS_W;
	localparam int unsigned CMP_W = rtpdfr_pkg::CMP_W;

	// input register
	logic       vld_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// result register
	logic                vld_s2;
	rtpdfr_pkg::result_t res_s2;

	// deframer state
	logic [POS_W-1:0] pos_q;
	logic [15:0]      ftb_q;
	logic [15:0]      seq_q;
	logic [31:0]      stamp_q;
	logic [31:0]      src_q;
	logic [31:0]      csrc_q;

	logic [POS_W-1:0] pos_n;
	logic [15:0]      ftb_n;
	logic [15:0]      seq_n;
	logic [31:0]      stamp_n;
	logic [31:0]      src_n;
	logic [31:0]      csrc_n;

	logic                advance;
	logic                process;
	logic                in_range;
	logic [CMP_W-1:0]    p_ext;
	logic [CMP_W-1:0]    hdr_len;
	logic                emit;
	rtpdfr_pkg::result_t res_n;
	rtpdfr_pkg::result_t drop_res;

	assign advance  = !vld_s2 || tx.ready;
	assign process  = vld_s1 && advance;
	assign rx.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			data_s1 <= rx.data_byte;
			last_s1 <= rx.last_byte;
		end
	end

	always_comb begin
		pos_n    = pos_q;
		ftb_n    = ftb_q;
		seq_n    = seq_q;
		stamp_n  = stamp_q;
		src_n    = src_q;
		csrc_n   = csrc_q;
		in_range = pos_q < POS_W'(rtpdfr_pkg::MAX_DATAGRAM);
		p_ext    = CMP_W'(pos_q);

		if (in_range) begin
			if (pos_q < POS_W'(2)) begin
				ftb_n = {ftb_q[7:0], data_s1};
			end else if (pos_q < POS_W'(4)) begin
				seq_n = {seq_q[7:0], data_s1};
			end else if (pos_q < POS_W'(8)) begin
				stamp_n = {stamp_q[23:0], data_s1};
			end else if (pos_q < POS_W'(rtpdfr_pkg::FIXED_LEN)) begin
				src_n = {src_q[23:0], data_s1};
			end
		end

		// csrc count is taken from the updated first byte
		hdr_len = CMP_W'(rtpdfr_pkg::FIXED_LEN) + CMP_W'({ftb_n[11:8], 2'b00});

		drop_res            = '0;
		drop_res.kind       = rtpdfr_pkg::KIND_DROP;
		drop_res.packet_end = 1'b1;

		res_n.kind           = rtpdfr_pkg::KIND_HEADER;
		res_n.version        = ftb_n[15:14];
		res_n.extension_flag = ftb_n[12];
		res_n.source_count   = ftb_n[11:8];
		res_n.marker         = ftb_n[7];
		res_n.payload_type   = ftb_n[6:0];
		res_n.sequence_res   = seq_n;
		res_n.stamp          = stamp_n;
		res_n.sync_source    = src_n;
		res_n.data_word      = '0;
		res_n.packet_end     = last_s1;
		emit                 = 1'b0;

		if (in_range) begin
			if (p_ext < CMP_W'(rtpdfr_pkg::FIXED_LEN - 1)) begin
				emit  = last_s1;
				res_n = drop_res;
			end else if (p_ext == CMP_W'(rtpdfr_pkg::FIXED_LEN - 1)) begin
				emit = 1'b1;
				if (last_s1 && (hdr_len > CMP_W'(rtpdfr_pkg::FIXED_LEN))) begin
					res_n = drop_res;
				end
			end else if (p_ext < hdr_len) begin
				csrc_n = {csrc_q[23:0], data_s1};
				// fixed header length is a multiple of four
				if (pos_q[1:0] == 2'b11) begin
					emit            = 1'b1;
					res_n.kind      = rtpdfr_pkg::KIND_CSRC;
					res_n.data_word = csrc_n;
				end else begin
					emit  = last_s1;
					res_n = drop_res;
				end
			end else begin
				emit            = 1'b1;
				res_n.kind      = rtpdfr_pkg::KIND_PAYLOAD;
				res_n.data_word = {24'd0, data_s1};
			end
			pos_n = pos_q + POS_W'(1);
		end else begin
			// saturated: bytes are discarded, only an unfinished header drops
			emit  = last_s1 && (p_ext < hdr_len);
			res_n = drop_res;
		end

		if (last_s1) begin
			pos_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ftb_q   <= '0;
			seq_q   <= '0;
			stamp_q <= '0;
			src_q   <= '0;
			csrc_q  <= '0;
		end else if (process) begin
			pos_q   <= pos_n;
			ftb_q   <= ftb_n;
			seq_q   <= seq_n;
			stamp_q <= stamp_n;
			src_q   <= src_n;
			csrc_q  <= csrc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= process && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (process && emit) begin
			res_s2 <= res_n;
		end
	end

	assign tx.valid          = vld_s2;
	assign tx.kind           = res_s2.kind;
	assign tx.version        = res_s2.version;
	assign tx.extension_flag = res_s2.extension_flag;
	assign tx.source_count   = res_s2.source_count;
	assign tx.marker         = res_s2.marker;
	assign tx.payload_type   = res_s2.payload_type;
	assign tx.sequence_res   = res_s2.sequence_res;
	assign tx.stamp          = res_s2.stamp;
	assign tx.sync_source    = res_s2.sync_source;
	assign tx.data_word      = res_s2.data_word;
	assign tx.packet_end     = res_s2.packet_end;

endmodule

`default_nettype wire

### rtl/rtpdfr_checker.sv
// ----------------------------------------------------------------------------
// rtpdfr_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpdfr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        tx_valid,
	input wire        tx_ready,
	input wire [1:0]  tx_kind,
	input wire [1:0]  tx_version,
	input wire [31:0] tx_stamp,
	input wire [31:0] tx_sync_source,
	input wire [31:0] tx_data_word,
	input wire        tx_packet_end
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid)
		else $error("result valid dropped during stall");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> $stable(tx_kind) && $stable(tx_data_word)
			&& $stable(tx_packet_end))
		else $error("result payload changed during stall");

	// drop transaction ends the datagram and carries no header
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (tx_kind == rtpdfr_pkg::KIND_DROP) |-> tx_packet_end
			&& (tx_version == 2'd0) && (tx_stamp == 32'd0)
			&& (tx_sync_source == 32'd0) && (tx_data_word == 32'd0))
		else $error("drop transaction with nonzero fields");

	// payload byte sits in the low byte, header result has no data word
	assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && ((tx_kind == rtpdfr_pkg::KIND_PAYLOAD)
			|| (tx_kind == rtpdfr_pkg::KIND_HEADER)) |-> (tx_data_word[31:8] == 24'd0)
			&& ((tx_kind == rtpdfr_pkg::KIND_PAYLOAD) || (tx_data_word == 32'd0)))
		else $error("data word out of range for transaction kind");

endmodule

bind rtp_header_deframer_top rtpdfr_checker u_rtpdfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tx_valid       (tx.valid),
	.tx_ready       (tx.ready),
	.tx_kind        (tx.kind),
	.tx_version     (tx.version),
	.tx_stamp       (tx.stamp),
	.tx_sync_source (tx.sync_source),
	.tx_data_word   (tx.data_word),
	.tx_packet_end  (tx.packet_end)
);

`default_nettype wire

### tb/rtpdfr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtpdfr_checker
// Watches both channels of the RTP deframer, tracks the datagram parse on
// its own and compares every result transaction against the oldest one due.
// ----------------------------------------------------------------------------
module tb_rtpdfr_checker (
	input  wire          clk,
	input  wire          arst_n,
	rtpdfr_in_if         rx,
	rtpdfr_out_if        tx,
	input  wire          run_done,
	output int unsigned  fail_count,
	output int unsigned  pending
);

	logic [16:0] byte_idx;
	logic [15:0] lead_bytes;
	logic [15:0] seq_word;
	logic [31:0] stamp_word;
	logic [31:0] ssrc_word;
	logic [31:0] csrc_acc;

	rtpdfr_pkg::result_t due_results[$];
	int unsigned errors = 0;
	int unsigned waiting = 0;
	int unsigned n_bytes = 0;
	int unsigned n_frames = 0;
	int unsigned n_ends = 0;
	int unsigned n_results = 0;
	int unsigned n_kind[4] = '{0, 0, 0, 0};

	assign fail_count = errors;
	assign pending    = waiting;

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("result %0d field %s got %0h want %0h",
				n_results, name, got, want));
	endtask

	function automatic rtpdfr_pkg::result_t header_result(input rtpdfr_pkg::kind_t k,
			input logic [31:0] w, input logic e);
		rtpdfr_pkg::result_t r;
		r.kind           = k;
		r.version        = lead_bytes[15:14];
		r.extension_flag = lead_bytes[12];
		r.source_count   = lead_bytes[11:8];
		r.marker         = lead_bytes[7];
		r.payload_type   = lead_bytes[6:0];
		r.sequence_res   = seq_word;
		r.stamp          = stamp_word;
		r.sync_source    = ssrc_word;
		r.data_word      = w;
		r.packet_end     = e;
		return r;
	endfunction

	function automatic rtpdfr_pkg::result_t drop_result();
		rtpdfr_pkg::result_t r;
		r            = '0;
		r.kind       = rtpdfr_pkg::KIND_DROP;
		r.packet_end = 1'b1;
		return r;
	endfunction

	// one datagram byte in, zero or one result due
	task automatic deframe_byte(input logic [7:0] b, input logic lst);
		logic [16:0]         p;
		logic [6:0]          hlen;
		logic                produce;
		rtpdfr_pkg::result_t r;
		p       = byte_idx;
		produce = 1'b0;
		r       = '0;
		hlen    = 7'(rtpdfr_pkg::FIXED_LEN + 4 * lead_bytes[11:8]);
		if (p < rtpdfr_pkg::MAX_DATAGRAM) begin
			if (p < 2)
				lead_bytes = {lead_bytes[7:0], b};
			else if (p < 4)
				seq_word = {seq_word[7:0], b};
			else if (p < 8)
				stamp_word = {stamp_word[23:0], b};
			else if (p < rtpdfr_pkg::FIXED_LEN)
				ssrc_word = {ssrc_word[23:0], b};
			// csrc count may have just arrived
			hlen = 7'(rtpdfr_pkg::FIXED_LEN + 4 * lead_bytes[11:8]);
			if (p < rtpdfr_pkg::FIXED_LEN - 1) begin
				if (lst) begin
					r       = drop_result();
					produce = 1'b1;
				end
			end else if (p == rtpdfr_pkg::FIXED_LEN - 1) begin
				if (lst && hlen > rtpdfr_pkg::FIXED_LEN)
					r = drop_result();
				else
					r = header_result(rtpdfr_pkg::KIND_HEADER, '0, lst);
				produce = 1'b1;
			end else if (p < hlen) begin
				csrc_acc = {csrc_acc[23:0], b};
				// header length is a multiple of four, so the low bits mark word ends
				if (p[1:0] == 2'b11) begin
					r       = header_result(rtpdfr_pkg::KIND_CSRC, csrc_acc, lst);
					produce = 1'b1;
				end else if (lst) begin
					r       = drop_result();
					produce = 1'b1;
				end
			end else begin
				r       = header_result(rtpdfr_pkg::KIND_PAYLOAD, {24'd0, b}, lst);
				produce = 1'b1;
			end
			byte_idx = p + 17'd1;
		end else if (lst && p < hlen) begin
			r       = drop_result();
			produce = 1'b1;
		end
		if (lst)
			byte_idx = '0;
		if (produce)
			due_results.push_back(r);
	endtask

	task automatic compare_result(input rtpdfr_pkg::result_t got,
			input rtpdfr_pkg::result_t want);
		check_field("kind", 32'(got.kind), 32'(want.kind));
		check_field("version", 32'(got.version), 32'(want.version));
		check_field("extension_flag", 32'(got.extension_flag), 32'(want.extension_flag));
		check_field("source_count", 32'(got.source_count), 32'(want.source_count));
		check_field("marker", 32'(got.marker), 32'(want.marker));
		check_field("payload_type", 32'(got.payload_type), 32'(want.payload_type));
		check_field("sequence_res", 32'(got.sequence_res), 32'(want.sequence_res));
		check_field("stamp", got.stamp, want.stamp);
		check_field("sync_source", got.sync_source, want.sync_source);
		check_field("data_word", got.data_word, want.data_word);
		check_field("packet_end", 32'(got.packet_end), 32'(want.packet_end));
	endtask

	always @(posedge clk or negedge arst_n) begin
		rtpdfr_pkg::result_t got;
		if (!arst_n) begin
			byte_idx   = '0;
			lead_bytes = '0;
			seq_word   = '0;
			stamp_word = '0;
			ssrc_word  = '0;
			csrc_acc   = '0;
			due_results.delete();
		end else begin
			// result side first: nothing accepted now can be due at this edge
			if (tx.valid === 1'b1 && tx.ready === 1'b1) begin
				got.kind           = rtpdfr_pkg::kind_t'(tx.kind);
				got.version        = tx.version;
				got.extension_flag = tx.extension_flag;
				got.source_count   = tx.source_count;
				got.marker         = tx.marker;
				got.payload_type   = tx.payload_type;
				got.sequence_res   = tx.sequence_res;
				got.stamp          = tx.stamp;
				got.sync_source    = tx.sync_source;
				got.data_word      = tx.data_word;
				got.packet_end     = tx.packet_end;
				n_kind[tx.kind]++;
				if (tx.packet_end === 1'b1)
					n_ends++;
				if (due_results.size() == 0)
					flag_mismatch($sformatf("result %0d of kind %0d with nothing due",
						n_results, tx.kind));
				else
					compare_result(got, due_results.pop_front());
				n_results++;
			end
			if (rx.valid === 1'b1 && rx.ready === 1'b1) begin
				n_bytes++;
				if (rx.last_byte)
					n_frames++;
				deframe_byte(rx.data_byte, rx.last_byte);
			end
		end
		waiting = due_results.size();
	end

	always @(posedge run_done) begin
		if (due_results.size() != 0)
			flag_mismatch($sformatf("%0d results still due at end of run",
				due_results.size()));
		$display("run covered %0d bytes in %0d datagrams, %0d results ended a datagram",
			n_bytes, n_frames, n_ends);
		$display("seen: %0d headers, %0d csrc words, %0d payload bytes, %0d drops",
			n_kind[rtpdfr_pkg::KIND_HEADER], n_kind[rtpdfr_pkg::KIND_CSRC],
			n_kind[rtpdfr_pkg::KIND_PAYLOAD], n_kind[rtpdfr_pkg::KIND_DROP]);
	end

endmodule

### tb/tb_rtp_header_deframer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rtp_header_deframer_top
// Feeds datagrams byte by byte into the RTP deframer: directed corner frames,
// then random well-formed, truncated and noise frames, with random idling
// on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_rtp_header_deframer_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        run_done = 1'b0;
	logic        calm = 1'b0;
	logic        hold_off_req = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	logic [7:0]  frame_bytes[$];

	rtpdfr_in_if  rx_if();
	rtpdfr_out_if tx_if();

	rtp_header_deframer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	tb_rtpdfr_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_if),
		.tx         (tx_if),
		.run_done   (run_done),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		tx_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_off_req) begin
				tx_if.ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_off_req = 1'b0;
			end
			stall = calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				tx_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			tx_if.ready <= 1'b1;
			do @(posedge clk); while (tx_if.valid !== 1'b1);
			@(negedge clk);
		end
	end

	// rtp frame: header with the given csrc count, then random payload
	task automatic build_rtp(input int srcs, input int pay_len);
		logic [1:0] ver;
		ver = ($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'd2;
		frame_bytes.delete();
		frame_bytes.push_back({ver, 1'($urandom), 1'($urandom), 4'(srcs)});
		repeat (11 + 4 * srcs + pay_len) frame_bytes.push_back(8'($urandom));
	endtask

	task automatic send_frame();
		int gap;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			gap = calm ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				rx_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rx_if.valid     <= 1'b1;
			rx_if.data_byte <= frame_bytes[i];
			rx_if.last_byte <= (i == frame_bytes.size() - 1);
			do @(posedge clk); while (rx_if.ready !== 1'b1);
			@(negedge clk);
		end
	endtask

	initial begin
		int unsigned rand_bytes;
		int          srcs;
		int          pay;
		int          sel;
		int          cut;
		bit          squeezed;
		rand_bytes      = 0;
		squeezed        = 1'b0;
		rx_if.valid     = 1'b0;
		rx_if.data_byte = '0;
		rx_if.last_byte = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// one-byte datagram
		frame_bytes = {8'hFF};
		send_frame();
		// bare header that ends the datagram
		frame_bytes = {8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame();
		// datagram ending on its only csrc word
		frame_bytes = {8'h31, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_frame();

		while (rand_bytes < 1650) begin
			sel  = $urandom_range(0, 99);
			srcs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
			pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
			if (!squeezed && rand_bytes >= 800) begin
				// back-to-back bytes against a stalled result side
				build_rtp(2, 60);
				calm         = 1'b1;
				hold_off_req = 1'b1;
				squeezed     = 1'b1;
			end else begin
				build_rtp(srcs, pay);
				if (sel < 15) begin
					cut = $urandom_range(1, rtpdfr_pkg::FIXED_LEN + 4 * srcs - 1);
					while (frame_bytes.size() > cut)
						void'(frame_bytes.pop_back());
				end else if (sel < 22) begin
					frame_bytes.delete();
					repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom));
				end
				calm = ($urandom_range(0, 5) == 0);
			end
			rand_bytes += frame_bytes.size();
			send_frame();
		end
		calm        = 1'b0;
		rx_if.valid <= 1'b0;

		for (int w = 0; w < 20000 && pending != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		run_done = 1'b1;
		#1;
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
rtl/rtpdfr_pkg.sv
rtl/rtpdfr_in_if.sv
rtl/rtpdfr_out_if.sv
rtl/rtp_header_deframer_top.sv
rtl/rtpdfr_checker.sv
tb/rtpdfr_checker.sv
tb/tb_rtp_header_deframer_top.sv
